FILE: src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, quiet while rst_n is low
`define DSSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also runs through reset
`define DSSC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/dssc_pkg.sv
// shared types and constants of the dominating set size counter
package dssc_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int VIDX_W       = 4;
  localparam int ROW_W        = 16;
  localparam int SIZE_W       = 5;
  localparam int CNT_W        = 17;
  localparam int NUM_CNT      = MAX_VERTICES + 1;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_START = 1'b1;

  localparam logic [SIZE_W-1:0] VCOUNT_RESET = SIZE_W'(MAX_VERTICES);

  // controller to datapath
  typedef struct packed {
    logic load;      // write one adjacency row
    logic clear;     // clear counters, subset and emit index
    logic step;      // test current subset and advance
    logic emit_adv;  // move one count into the output register
    logic emit_sel;  // counter read port follows the emit index
  } dssc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic walk_done;  // current subset is the last one
    logic emit_last;  // emit index points at size n
    logic out_free;   // output register can take a word
  } dssc_sts_t;

endpackage

FILE: src/dssc_ctrl.sv
// controller state machine of the dominating set size counter
module dssc_ctrl
  import dssc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_kind,
  input  dssc_sts_t sts,
  output dssc_cmd_t cmd,
  output logic      idle
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_kind == KIND_LOAD) begin
          cmd.load = 1'b1;
        end else if (in_valid && in_kind == KIND_START) begin
          cmd.clear = 1'b1;
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        cmd.step = 1'b1;
        if (sts.walk_done) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit_sel = 1'b1;
        if (sts.out_free) begin
          cmd.emit_adv = 1'b1;
          if (sts.emit_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign idle = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: src/dssc_datapath.sv
// datapath: rows, subset walk, size counters and output register
module dssc_datapath
  import dssc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  dssc_cmd_t         cmd,
  output dssc_sts_t         sts,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_vertex_count,
  input  logic [VIDX_W-1:0] in_row_vertex,
  input  logic [ROW_W-1:0]  in_neighbor_mask,
  input  logic              out_stall,
  output logic              out_valid,
  output logic [SIZE_W-1:0] out_set_size,
  output logic [CNT_W-1:0]  out_set_count,
  output logic              out_last
);

  function automatic logic [SIZE_W-1:0] pop16(input logic [ROW_W-1:0] v);
    logic [SIZE_W-1:0] acc;
    logic [2:0]        nib;
    acc = '0;
    for (int k = 0; k < ROW_W / 4; k++) begin
      nib = 3'(v[4*k]) + 3'(v[4*k+1]) + 3'(v[4*k+2]) + 3'(v[4*k+3]);
      acc = acc + SIZE_W'(nib);
    end
    return acc;
  endfunction

  logic [SIZE_W-1:0] vcount_r;
  logic [SIZE_W-1:0] n_eff;
  logic [ROW_W-1:0]  full_mask;
  logic [ROW_W-1:0]  rows_r [MAX_VERTICES];
  logic [ROW_W-1:0]  subset_r;
  logic [ROW_W-1:0]  covered;
  logic              s1_valid_r;
  logic              s1_dom_r;
  logic [SIZE_W-1:0] s1_size_r;
  logic [CNT_W-1:0]  counters_r [NUM_CNT];
  logic [SIZE_W-1:0] rd_addr;
  logic [CNT_W-1:0]  rd_data;
  logic [SIZE_W-1:0] emit_idx_r;
  logic              out_valid_r;
  logic [SIZE_W-1:0] out_size_r;
  logic [CNT_W-1:0]  out_count_r;
  logic              out_last_r;

  // vertex count saturates at the array size
  assign n_eff = (vcount_r > SIZE_W'(MAX_VERTICES)) ? SIZE_W'(MAX_VERTICES) : vcount_r;

  always_comb begin
    for (int j = 0; j < ROW_W; j++) begin
      full_mask[j] = (SIZE_W'(j) < n_eff);
    end
  end

  // union of closed neighborhoods of the chosen vertices
  always_comb begin
    covered = '0;
    for (int j = 0; j < MAX_VERTICES; j++) begin
      if (subset_r[j]) begin
        covered = covered | rows_r[j] | (ROW_W'(1) << j);
      end
    end
  end

  assign rd_addr = cmd.emit_sel ? emit_idx_r : s1_size_r;
  assign rd_data = counters_r[rd_addr];

  assign sts.walk_done = (subset_r == full_mask);
  assign sts.emit_last = (emit_idx_r == n_eff);
  assign sts.out_free  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= VCOUNT_RESET;
    end else if (cfg_we) begin
      vcount_r <= cfg_vertex_count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < MAX_VERTICES; j++) begin
        rows_r[j] <= '0;
      end
    end else if (cmd.load) begin
      rows_r[in_row_vertex] <= in_neighbor_mask;
    end
  end

  // subset test stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      subset_r   <= '0;
      s1_valid_r <= 1'b0;
    end else if (cmd.clear) begin
      subset_r   <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= cmd.step;
      if (cmd.step) begin
        subset_r <= sts.walk_done ? '0 : subset_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_dom_r  <= ((covered & full_mask) == full_mask);
    s1_size_r <= pop16(subset_r);
  end

  // size counters
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      for (int k = 0; k < NUM_CNT; k++) begin
        counters_r[k] <= '0;
      end
    end else if (s1_valid_r && s1_dom_r && !cmd.emit_sel) begin
      counters_r[rd_addr] <= CNT_W'(rd_data + 1'b1);
    end
  end

  // emit index and output register
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      emit_idx_r <= '0;
    end else if (cmd.emit_adv) begin
      emit_idx_r <= emit_idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_adv) begin
      out_size_r  <= emit_idx_r;
      out_count_r <= rd_data;
      out_last_r  <= sts.emit_last;
    end
  end

  // no result shows while reset is held
  assign out_valid     = out_valid_r && rst_n;
  assign out_set_size  = out_size_r;
  assign out_set_count = out_count_r;
  assign out_last      = out_last_r;

endmodule

FILE: src/dominating_set_size_counter.sv
// top level of the dominating set size counter
//
// Counts the dominating sets of a graph of up to 16 vertices, by set size.
// A load word (kind 0) writes the neighbor row of one vertex. A start word
// (kind 1) clears the size counters and walks every subset of the first n
// vertices, n being the configured vertex count saturated at 16. One subset
// is tested per cycle: the closed neighborhoods of the chosen vertices are
// OR-ed together and, when they cover all n vertices, the counter for the
// subset's size is bumped. The walk is a binary counter through a single
// two-stage test unit, so a start word walks 2^n subsets, drains the test
// unit and then gives n + 1 result words, one per cycle when the output
// side does not stall. Results come out in size order 0 through n, with
// last set on size n. Rows are used as written, without symmetrizing; row
// bits at or above n are ignored. No new input word is taken until the last
// result has moved into the output register; that register lets the next
// word be taken while the final result waits. Vertex count writes are
// taken only while the block is idle (cfg_ready high). While rst_n is low
// the input is stalled, cfg_ready is low and no result is shown. Reset
// gives all rows zero and a vertex count of 16.
module dominating_set_size_counter
  import dssc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // input words
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_kind,
  input  logic [VIDX_W-1:0] in_row_vertex,
  input  logic [ROW_W-1:0]  in_neighbor_mask,
  // result words
  output logic              out_valid,
  input  logic              out_stall,
  output logic [SIZE_W-1:0] out_set_size,
  output logic [CNT_W-1:0]  out_set_count,
  output logic              out_last,
  // vertex count register
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [SIZE_W-1:0] cfg_vertex_count
);

  dssc_cmd_t cmd;
  dssc_sts_t sts;
  logic      idle;

  // only idle takes words, either on the input or on the config port,
  // and nothing is taken while reset is held
  assign in_stall  = !idle || !rst_n;
  assign cfg_ready = idle && rst_n;

  dssc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .sts      (sts),
    .cmd      (cmd),
    .idle     (idle)
  );

  dssc_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_vertex_count (cfg_vertex_count),
    .in_row_vertex    (in_row_vertex),
    .in_neighbor_mask (in_neighbor_mask),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_set_size     (out_set_size),
    .out_set_count    (out_set_count),
    .out_last         (out_last)
  );

endmodule

FILE: src/dssc_checker.sv
// port-level checks of the dominating set size counter and their bind
`include "assert_macros.svh"

module dssc_checker
  import dssc_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              in_kind,
  input logic              out_valid,
  input logic              out_stall,
  input logic [SIZE_W-1:0] out_set_size,
  input logic [CNT_W-1:0]  out_set_count,
  input logic              out_last,
  input logic              cfg_ready
);

  // a stalled result word keeps all its fields
  property p_out_hold;
    out_valid && out_stall |=> out_valid && $stable(out_set_size) &&
      $stable(out_set_count) && $stable(out_last);
  endproperty

  property p_start_busy;
    in_valid && !in_stall && in_kind == KIND_START |=> in_stall;
  endproperty

  property p_size_range;
    out_valid |-> out_set_size <= SIZE_W'(MAX_VERTICES);
  endproperty

  `DSSC_ASSERT(a_out_hold, p_out_hold, "stalled result word changed")
  `DSSC_ASSERT(a_start_busy, p_start_busy, "start word did not make the block busy")
  `DSSC_ASSERT(a_size_range, p_size_range, "set size out of range")
  `DSSC_ASSERT(a_cfg_idle, in_stall |-> !cfg_ready, "config taken while busy")
  `DSSC_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid, "result word right after reset")

endmodule

bind dominating_set_size_counter dssc_checker u_dssc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .in_kind       (in_kind),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_set_size  (out_set_size),
  .out_set_count (out_set_count),
  .out_last      (out_last),
  .cfg_ready     (cfg_ready)
);
